// ===== hdl/page_frame_bitmap_allocator_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// checked only while out of reset
`define PFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define PFBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/pfba_pkg.sv =====
`timescale 1ns / 1ps

package pfba_pkg;

    localparam int CNT_W         = 17;
    localparam int IDX_W         = 16;
    localparam int WORD_BITS     = 64;
    localparam int BIT_W         = 6;
    localparam int WIDX_W        = IDX_W - BIT_W;
    localparam int PAGE_SPACE    = 65536;
    localparam int DEF_NUM_PAGES = 65536;

    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WIDX_W-1:0]    t_widx;
    typedef logic [BIT_W-1:0]     t_bit;

    localparam t_cnt CNT_MAX    = '1;
    localparam t_cnt TOTAL_RST  = 17'd65536;

    localparam logic [2:0] OP_REQUEST   = 3'd0;
    localparam logic [2:0] OP_LOCK      = 3'd1;
    localparam logic [2:0] OP_FREE      = 3'd2;
    localparam logic [2:0] OP_RESERVE   = 3'd3;
    localparam logic [2:0] OP_UNRESERVE = 3'd4;
    localparam logic [2:0] OP_INIT      = 3'd5;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_SAME   = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic hit;
        t_bit pos;
    } t_scan_res;

    function automatic t_cnt inc_sat(input t_cnt v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

    function automatic t_cnt dec_sat(input t_cnt v);
        return (v == '0) ? '0 : v - 1'b1;
    endfunction

endpackage

// ===== hdl/pfba_word_scan.sv =====
`timescale 1ns / 1ps

module pfba_word_scan import pfba_pkg::*; (
    input  t_word     i_word,
    input  t_widx     i_widx,
    input  t_cnt      i_lim,
    output t_scan_res o_res
);

    logic [CNT_W-BIT_W-1:0] lim_word;
    t_bit                   lim_bit;
    t_word                  mask;
    t_word                  free_bits;
    t_word                  first_bit;
    t_bit                   pos;

    assign lim_word = i_lim[CNT_W-1:BIT_W];
    assign lim_bit  = i_lim[BIT_W-1:0];

    // pages at or above the limit never qualify
    always_comb begin
        priority if ({1'b0, i_widx} < lim_word) begin
            mask = '1;
        end else if ({1'b0, i_widx} == lim_word) begin
            mask = (t_word'(1) << lim_bit) - t_word'(1);
        end else begin
            mask = '0;
        end
    end

    assign free_bits = ~i_word & mask;
    assign first_bit = free_bits & (~free_bits + t_word'(1));

    always_comb begin
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (first_bit[b]) begin
                pos = pos | t_bit'(b);
            end
        end
    end

    assign o_res.hit = |free_bits;
    assign o_res.pos = pos;

endmodule

// ===== hdl/page_frame_bitmap_allocator_unit.sv =====
`timescale 1ns / 1ps
// lock, free, reserve, unreserve: pass through the read, modify and output states before the result is valid
// out-of-range index, unused opcode or request with no pages: go straight to the output state
// request: scans from map word 0 up to the word of the last page, one 64-bit map word read per cycle
// initialize: one map word cleared per cycle, 1024 map words at the default size
// one item in flight; a finished result waits in the output register while the next is taken
// reset: a clearing pass of one word per cycle over all map words, input ready low meanwhile

module page_frame_bitmap_allocator_unit import pfba_pkg::*; #(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0]       i_opcode,
    input  logic [IDX_W-1:0] i_page_index,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_granted_page,
    output logic [CNT_W-1:0] o_avail_pages,
    output logic [CNT_W-1:0] o_used_pages,
    output logic [CNT_W-1:0] o_reserved_pages
);

    localparam int SPAN_PAGES = (NUM_PAGES < PAGE_SPACE) ? NUM_PAGES : PAGE_SPACE;
    localparam int MEM_WORDS  = (SPAN_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam t_cnt  PAGE_CAP      = CNT_W'(SPAN_PAGES);
    localparam t_widx LAST_MEM_WORD = WIDX_W'(MEM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_MOD,
        S_SRCH,
        S_OUT
    } t_state;

    t_state           r_state;
    t_word            r_map [MEM_WORDS];
    t_word            r_rdata;
    t_cnt             r_total;
    t_cnt             r_free;
    t_cnt             r_used;
    t_cnt             r_rsv;
    logic [2:0]       r_op;
    logic [IDX_W-1:0] r_idx;
    t_widx            r_scan;
    t_widx            r_dword;
    logic             r_pend;
    logic             r_init;
    logic [1:0]       r_st;
    logic [IDX_W-1:0] r_gnt;
    logic             r_ovalid;
    logic [1:0]       r_o_status;
    logic [IDX_W-1:0] r_o_gnt;
    t_cnt             r_o_free;
    t_cnt             r_o_used;
    t_cnt             r_o_rsv;

    t_cnt      lim;
    t_cnt      lim_m1;
    t_widx     last_word;
    t_widx     raddr;
    t_widx     waddr;
    t_word     wdata;
    logic      mem_we;
    logic      want;
    logic      same;
    t_word     mod_word;
    t_scan_res scan;

    assign lim       = (r_total < PAGE_CAP) ? r_total : PAGE_CAP;
    assign lim_m1    = lim - 1'b1;
    assign last_word = lim_m1[CNT_W-2:BIT_W];

    assign want = (r_op == OP_LOCK) || (r_op == OP_RESERVE);
    assign same = (r_rdata[r_idx[BIT_W-1:0]] == want);

    always_comb begin
        mod_word = r_rdata;
        mod_word[r_idx[BIT_W-1:0]] = want;
    end

    pfba_word_scan u_scan (
        .i_word (r_rdata),
        .i_widx (r_dword),
        .i_lim  (lim),
        .o_res  (scan)
    );

    always_comb begin
        raddr  = (r_state == S_SRCH) ? r_scan : r_idx[IDX_W-1:BIT_W];
        mem_we = 1'b0;
        waddr  = r_idx[IDX_W-1:BIT_W];
        wdata  = mod_word;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                waddr  = r_scan;
                wdata  = '0;
            end
            S_MOD: begin
                mem_we = !same;
            end
            S_SRCH: begin
                mem_we = r_pend && scan.hit;
                waddr  = r_dword;
                wdata  = r_rdata | (t_word'(1) << scan.pos);
            end
            S_IDLE, S_RD, S_OUT: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[AW'(waddr)] <= wdata;
        end
        r_rdata <= r_map[AW'(raddr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_scan   <= '0;
            r_pend   <= 1'b0;
            r_init   <= 1'b0;
            r_ovalid <= 1'b0;
            r_total  <= TOTAL_RST;
            r_free   <= '0;
            r_used   <= '0;
            r_rsv    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_scan == LAST_MEM_WORD) begin
                        r_scan <= '0;
                        if (r_init) begin
                            r_free  <= lim;
                            r_used  <= '0;
                            r_rsv   <= '0;
                            r_st    <= ST_DONE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_opcode;
                        r_idx  <= i_page_index;
                        r_gnt  <= '0;
                        r_scan <= '0;
                        r_pend <= 1'b0;
                        r_init <= (i_opcode == OP_INIT);
                        priority if (i_opcode == OP_REQUEST) begin
                            if (lim == '0) begin
                                r_st    <= ST_NOFREE;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SRCH;
                            end
                        end else if (i_opcode == OP_INIT) begin
                            r_state <= S_CLEAR;
                        end else if (i_opcode == OP_LOCK || i_opcode == OP_FREE ||
                                     i_opcode == OP_RESERVE || i_opcode == OP_UNRESERVE) begin
                            if ({1'b0, i_page_index} >= lim) begin
                                r_st    <= ST_RANGE;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else begin
                            r_st    <= ST_SAME;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (same) begin
                        r_st <= ST_SAME;
                    end else begin
                        r_st <= ST_DONE;
                        priority if (r_op == OP_LOCK) begin
                            r_free <= dec_sat(r_free);
                            r_used <= inc_sat(r_used);
                        end else if (r_op == OP_FREE) begin
                            r_free <= inc_sat(r_free);
                            r_used <= dec_sat(r_used);
                        end else if (r_op == OP_RESERVE) begin
                            r_free <= dec_sat(r_free);
                            r_rsv  <= inc_sat(r_rsv);
                        end else begin
                            r_free <= inc_sat(r_free);
                            r_rsv  <= dec_sat(r_rsv);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_SRCH: begin
                    r_pend  <= 1'b1;
                    r_dword <= r_scan;
                    if (r_scan != last_word) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (r_pend) begin
                        if (scan.hit) begin
                            r_gnt   <= {r_dword, scan.pos};
                            r_free  <= dec_sat(r_free);
                            r_used  <= inc_sat(r_used);
                            r_st    <= ST_DONE;
                            r_state <= S_OUT;
                        end else if (r_dword == last_word) begin
                            r_st    <= ST_NOFREE;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_st;
                        r_o_gnt    <= r_gnt;
                        r_o_free   <= r_free;
                        r_o_used   <= r_used;
                        r_o_rsv    <= r_rsv;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_o_status;
    assign o_granted_page   = r_o_gnt;
    assign o_avail_pages    = r_o_free;
    assign o_used_pages     = r_o_used;
    assign o_reserved_pages = r_o_rsv;

endmodule

// ===== hdl/pfba_checker.sv =====
`timescale 1ns / 1ps
`include "page_frame_bitmap_allocator_unit_defines.svh"

module pfba_checker import pfba_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [1:0]       o_status,
    input logic [IDX_W-1:0] o_granted_page
);

    // stalled result stays presented
    `PFBA_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_granted_page), "result dropped or changed while stalled")

    // only a successful request carries a page number
    `PFBA_ASSERT(a_gnt_zero, o_valid && (o_status != ST_DONE) |-> (o_granted_page == '0), "page number on a failed or non-request result")

    // one item at a time
    `PFBA_ASSERT(a_busy_after, i_valid && o_ready |=> !o_ready, "ready held after an input transfer")

    // no result straight out of reset
    `PFBA_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind page_frame_bitmap_allocator_unit pfba_checker u_pfba_checker (.*);
